>>> sv/wtpc_pkg.sv
`default_nettype none

package wtpc_pkg;

    localparam int CELL_COUNT    = 9;
    localparam int PATTERN_COUNT = 46;
    localparam int CELL_W        = 4;
    localparam int SPRITE_W      = 6;

    localparam logic [CELL_W-1:0] CT_LAST_PATH  = 4'd4;
    localparam logic [CELL_W-1:0] CT_WALL       = 4'd5;
    localparam logic [CELL_W-1:0] CT_GHOST_WALL = 4'd6;
    localparam logic [CELL_W-1:0] CT_DOOR       = 4'd7;

    typedef enum logic [2:0] {
        S_ANY,
        S_PTH,
        S_OUT,
        S_WAL,
        S_GHW,
        S_AWL,
        S_WOO,
        S_DOR
    } sym_t;

    typedef sym_t [CELL_COUNT-1:0] cells_t;

    typedef struct packed {
        logic [SPRITE_W-1:0] sprite;
        cells_t              cells;
    } pat_t;

    typedef struct packed {
        logic [CELL_W-1:0] cell_nw;
        logic [CELL_W-1:0] cell_n;
        logic [CELL_W-1:0] cell_ne;
        logic [CELL_W-1:0] cell_w;
        logic [CELL_W-1:0] cell_c;
        logic [CELL_W-1:0] cell_e;
        logic [CELL_W-1:0] cell_sw;
        logic [CELL_W-1:0] cell_s;
        logic [CELL_W-1:0] cell_se;
        logic [CELL_COUNT-1:0] outside_mask;
    } item_t;

    typedef struct packed {
        logic                has_sprite;
        logic [SPRITE_W-1:0] sprite_index;
        logic                pattern_miss;
    } result_t;

    // nw first, se last; nw lands in cell 0
    function automatic cells_t pk(input sym_t c0, input sym_t c1, input sym_t c2,
                                 input sym_t c3, input sym_t c4, input sym_t c5,
                                 input sym_t c6, input sym_t c7, input sym_t c8);
        cells_t r;
        r[0] = c0; r[1] = c1; r[2] = c2;
        r[3] = c3; r[4] = c4; r[5] = c5;
        r[6] = c6; r[7] = c7; r[8] = c8;
        return r;
    endfunction

    function automatic logic sym_match(input sym_t sym, input logic [CELL_W-1:0] content,
                                       input logic outside);
        logic m;
        case (sym)
            S_ANY:   m = 1'b1;
            S_PTH:   m = !outside && (content <= CT_LAST_PATH);
            S_OUT:   m = outside;
            S_WAL:   m = (content == CT_WALL);
            S_GHW:   m = (content == CT_GHOST_WALL);
            S_AWL:   m = (content == CT_WALL) || (content == CT_GHOST_WALL);
            S_WOO:   m = (content == CT_WALL) || (content == CT_GHOST_WALL) || outside;
            S_DOR:   m = (content == CT_DOOR);
            default: m = 1'b0;
        endcase
        return m;
    endfunction

    localparam pat_t PATTERNS [PATTERN_COUNT] = '{
        '{6'd0,  pk(S_WAL,S_WAL,S_WAL, S_WAL,S_WAL,S_WAL, S_WAL,S_WAL,S_WAL)},
        '{6'd1,  pk(S_ANY,S_WAL,S_WAL, S_PTH,S_WAL,S_WAL, S_ANY,S_WAL,S_WAL)},
        '{6'd2,  pk(S_ANY,S_PTH,S_ANY, S_WAL,S_WAL,S_WAL, S_WAL,S_WAL,S_WAL)},
        '{6'd3,  pk(S_WAL,S_WAL,S_ANY, S_WAL,S_WAL,S_PTH, S_WAL,S_WAL,S_ANY)},
        '{6'd4,  pk(S_WAL,S_WAL,S_WAL, S_WAL,S_WAL,S_WAL, S_ANY,S_PTH,S_ANY)},
        '{6'd5,  pk(S_PTH,S_PTH,S_PTH, S_PTH,S_WAL,S_WAL, S_PTH,S_WAL,S_WAL)},
        '{6'd6,  pk(S_PTH,S_PTH,S_PTH, S_WAL,S_WAL,S_PTH, S_WAL,S_WAL,S_PTH)},
        '{6'd7,  pk(S_WAL,S_WAL,S_PTH, S_WAL,S_WAL,S_PTH, S_PTH,S_PTH,S_PTH)},
        '{6'd8,  pk(S_PTH,S_WAL,S_WAL, S_PTH,S_WAL,S_WAL, S_PTH,S_PTH,S_PTH)},
        '{6'd9,  pk(S_PTH,S_WAL,S_WAL, S_WAL,S_WAL,S_WAL, S_WAL,S_WAL,S_WAL)},
        '{6'd10, pk(S_WAL,S_WAL,S_PTH, S_WAL,S_WAL,S_WAL, S_WAL,S_WAL,S_WAL)},
        '{6'd11, pk(S_WAL,S_WAL,S_WAL, S_WAL,S_WAL,S_WAL, S_WAL,S_WAL,S_PTH)},
        '{6'd12, pk(S_WAL,S_WAL,S_WAL, S_WAL,S_WAL,S_WAL, S_PTH,S_WAL,S_WAL)},
        '{6'd17, pk(S_PTH,S_PTH,S_ANY, S_PTH,S_WAL,S_WOO, S_ANY,S_WAL,S_OUT)},
        '{6'd18, pk(S_ANY,S_PTH,S_PTH, S_WOO,S_WAL,S_PTH, S_OUT,S_WAL,S_ANY)},
        '{6'd19, pk(S_OUT,S_WAL,S_ANY, S_WOO,S_WAL,S_PTH, S_ANY,S_PTH,S_PTH)},
        '{6'd20, pk(S_ANY,S_WAL,S_OUT, S_PTH,S_WAL,S_WOO, S_PTH,S_PTH,S_ANY)},
        '{6'd13, pk(S_ANY,S_ANY,S_ANY, S_PTH,S_AWL,S_OUT, S_ANY,S_ANY,S_ANY)},
        '{6'd14, pk(S_ANY,S_PTH,S_ANY, S_ANY,S_AWL,S_ANY, S_ANY,S_OUT,S_ANY)},
        '{6'd15, pk(S_ANY,S_ANY,S_ANY, S_OUT,S_AWL,S_PTH, S_ANY,S_ANY,S_ANY)},
        '{6'd16, pk(S_ANY,S_OUT,S_ANY, S_ANY,S_AWL,S_ANY, S_ANY,S_PTH,S_ANY)},
        '{6'd21, pk(S_ANY,S_ANY,S_ANY, S_ANY,S_DOR,S_ANY, S_ANY,S_ANY,S_ANY)},
        '{6'd22, pk(S_PTH,S_WAL,S_ANY, S_WAL,S_WAL,S_OUT, S_ANY,S_OUT,S_OUT)},
        '{6'd23, pk(S_ANY,S_WAL,S_PTH, S_OUT,S_WAL,S_WAL, S_OUT,S_OUT,S_ANY)},
        '{6'd24, pk(S_OUT,S_OUT,S_ANY, S_OUT,S_WAL,S_WAL, S_ANY,S_WAL,S_PTH)},
        '{6'd25, pk(S_ANY,S_OUT,S_OUT, S_WAL,S_WAL,S_OUT, S_PTH,S_WAL,S_ANY)},
        '{6'd26, pk(S_PTH,S_WAL,S_OUT, S_WAL,S_WAL,S_OUT, S_WAL,S_WAL,S_OUT)},
        '{6'd27, pk(S_OUT,S_WAL,S_PTH, S_OUT,S_WAL,S_WAL, S_OUT,S_WAL,S_WAL)},
        '{6'd28, pk(S_OUT,S_WAL,S_WAL, S_OUT,S_WAL,S_WAL, S_OUT,S_WAL,S_PTH)},
        '{6'd29, pk(S_WAL,S_WAL,S_OUT, S_WAL,S_WAL,S_OUT, S_PTH,S_WAL,S_OUT)},
        '{6'd30, pk(S_PTH,S_WAL,S_WAL, S_WAL,S_WAL,S_WAL, S_OUT,S_OUT,S_OUT)},
        '{6'd31, pk(S_WAL,S_WAL,S_PTH, S_WAL,S_WAL,S_WAL, S_OUT,S_OUT,S_OUT)},
        '{6'd32, pk(S_OUT,S_OUT,S_OUT, S_WAL,S_WAL,S_WAL, S_WAL,S_WAL,S_PTH)},
        '{6'd33, pk(S_OUT,S_OUT,S_OUT, S_WAL,S_WAL,S_WAL, S_PTH,S_WAL,S_WAL)},
        '{6'd34, pk(S_PTH,S_PTH,S_PTH, S_PTH,S_GHW,S_GHW, S_PTH,S_GHW,S_OUT)},
        '{6'd35, pk(S_PTH,S_PTH,S_PTH, S_GHW,S_GHW,S_PTH, S_OUT,S_GHW,S_PTH)},
        '{6'd36, pk(S_OUT,S_GHW,S_PTH, S_GHW,S_GHW,S_PTH, S_PTH,S_PTH,S_PTH)},
        '{6'd37, pk(S_PTH,S_GHW,S_OUT, S_PTH,S_GHW,S_GHW, S_PTH,S_PTH,S_PTH)},
        '{6'd38, pk(S_OUT,S_PTH,S_ANY, S_OUT,S_WAL,S_WAL, S_OUT,S_WAL,S_WAL)},
        '{6'd39, pk(S_ANY,S_PTH,S_OUT, S_WAL,S_WAL,S_OUT, S_WAL,S_WAL,S_OUT)},
        '{6'd40, pk(S_OUT,S_WAL,S_WAL, S_OUT,S_WAL,S_WAL, S_OUT,S_PTH,S_ANY)},
        '{6'd41, pk(S_WAL,S_WAL,S_OUT, S_WAL,S_WAL,S_OUT, S_ANY,S_PTH,S_OUT)},
        '{6'd42, pk(S_OUT,S_OUT,S_OUT, S_PTH,S_WAL,S_WAL, S_ANY,S_WAL,S_WAL)},
        '{6'd43, pk(S_OUT,S_OUT,S_OUT, S_WAL,S_WAL,S_PTH, S_WAL,S_WAL,S_ANY)},
        '{6'd44, pk(S_ANY,S_WAL,S_WAL, S_PTH,S_WAL,S_WAL, S_OUT,S_OUT,S_OUT)},
        '{6'd45, pk(S_WAL,S_WAL,S_ANY, S_WAL,S_WAL,S_PTH, S_OUT,S_OUT,S_OUT)}
    };

endpackage

`default_nettype wire

>>> sv/wall_tile_pattern_classifier.sv
// Channel | Handshake           | Payload
// ------- | ------------------- | ---------------------------------------
// input   | start, busy         | item   (nine cell codes, outside_mask)
// result  | done (one cycle)    | result (has_sprite, sprite_index, miss)
//
// One beat is taken every cycle; busy stays low.
// Each result appears on done once its start beat has passed the input
// register and then the 46-pattern compare and first-match select into the
// result register.
// Reset clears both valid flags; nothing is lost since no state spans beats.
// The receiver cannot stall; done is a one-cycle strobe.
`default_nettype none

module wall_tile_pattern_classifier (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              start,
    output logic                   busy,
    input  wire wtpc_pkg::item_t   item,
    output logic                   done,
    output wtpc_pkg::result_t      result
);
    import wtpc_pkg::*;

    logic    in_valid_reg;
    item_t   item_reg;
    logic    out_valid_reg;
    result_t result_reg;
    result_t result_next;

    logic [CELL_W-1:0]        cells [CELL_COUNT];
    logic [PATTERN_COUNT-1:0] hit;
    logic                     centre_wall;
    logic [SPRITE_W-1:0]      first_sprite;

    assign busy = 1'b0;

    always_comb
    begin
        cells[0] = item_reg.cell_nw;
        cells[1] = item_reg.cell_n;
        cells[2] = item_reg.cell_ne;
        cells[3] = item_reg.cell_w;
        cells[4] = item_reg.cell_c;
        cells[5] = item_reg.cell_e;
        cells[6] = item_reg.cell_sw;
        cells[7] = item_reg.cell_s;
        cells[8] = item_reg.cell_se;
    end

    always_comb
    begin
        for (int p = 0; p < PATTERN_COUNT; p++)
        begin
            hit[p] = 1'b1;
            for (int k = 0; k < CELL_COUNT; k++)
            begin
                hit[p] = hit[p] &&
                         sym_match(PATTERNS[p].cells[k], cells[k], item_reg.outside_mask[k]);
            end
        end
    end

    // first match in table order wins
    always_comb
    begin
        first_sprite = '0;
        for (int p = PATTERN_COUNT - 1; p >= 0; p--)
        begin
            if (hit[p])
            begin
                first_sprite = PATTERNS[p].sprite;
            end
        end
    end

    assign centre_wall = (item_reg.cell_c == CT_WALL) ||
                         (item_reg.cell_c == CT_GHOST_WALL) ||
                         (item_reg.cell_c == CT_DOOR);

    always_comb
    begin
        result_next = '0;
        if (centre_wall)
        begin
            if (|hit)
            begin
                result_next.has_sprite   = 1'b1;
                result_next.sprite_index = first_sprite;
            end
            else
            begin
                result_next.pattern_miss = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            result_reg    <= '0;
        end
        else
        begin
            in_valid_reg  <= start && !busy;
            out_valid_reg <= in_valid_reg;
            if (in_valid_reg)
            begin
                result_reg <= result_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start && !busy)
        begin
            item_reg <= item;
        end
    end

    assign done   = out_valid_reg;
    assign result = result_reg;

    a_flags_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !(result.has_sprite && result.pattern_miss))
        else $error("sprite and miss flagged together");

    a_index_zero_without_sprite: assert property (@(posedge clk) disable iff (!rst_n)
        (done && !result.has_sprite) |-> (result.sprite_index == '0))
        else $error("sprite index set without sprite");

    a_done_follows_start: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start, 2))
        else $error("result without a start beat two cycles earlier");

    a_hold_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
        !in_valid_reg |=> $stable(result_reg))
        else $error("result register moved without a beat in flight");

endmodule

`default_nettype wire

>>> sim/tile_sprite_checker.sv
module tile_sprite_checker (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic              busy,
    input  wtpc_pkg::item_t   item,
    input  logic              done,
    input  wtpc_pkg::result_t result,
    output int                mismatch_count,
    output int                sprites_owed
);
    timeunit 1ns;
    timeprecision 1ps;

    import wtpc_pkg::*;

    // nine symbols per shape, nw first, se last
    localparam logic [8*CELL_COUNT-1:0] TILE_SHAPES [PATTERN_COUNT] = '{
        "WWWWWWWWW", " WW.WW WW", " . WWWWWW", "WW WW.WW ", "WWWWWW . ",
        "....WW.WW", "...WW.WW.", "WW.WW....", ".WW.WW...", ".WWWWWWWW",
        "WW.WWWWWW", "WWWWWWWW.", "WWWWWW.WW", ".. .WX WO", " ..XW.OW ",
        "OW XW. ..", " WO.WX.. ", "   .AO   ", " .  A  O ", "   OA.   ",
        " O  A  . ", "    -    ", ".W WWO OO", " W.OWWOO ", "OO OWW W.",
        " OOWWO.W ", ".WOWWOWWO", "OW.OWWOWW", "OWWOWWOW.", "WWOWWO.WO",
        ".WWWWWOOO", "WW.WWWOOO", "OOOWWWWW.", "OOOWWW.WW", "....GG.GO",
        "...GG.OG.", "OG.GG....", ".GO.GG...", "O. OWWOWW", " .OWWOWWO",
        "OWWOWWO. ", "WWOWWO .O", "OOO.WW WW", "OOOWW.WW ", " WW.WWOOO",
        "WW WW.OOO"
    };

    localparam logic [SPRITE_W-1:0] TILE_SPRITES [PATTERN_COUNT] = '{
        6'd0,  6'd1,  6'd2,  6'd3,  6'd4,  6'd5,  6'd6,  6'd7,  6'd8,  6'd9,
        6'd10, 6'd11, 6'd12, 6'd17, 6'd18, 6'd19, 6'd20, 6'd13, 6'd14, 6'd15,
        6'd16, 6'd21, 6'd22, 6'd23, 6'd24, 6'd25, 6'd26, 6'd27, 6'd28, 6'd29,
        6'd30, 6'd31, 6'd32, 6'd33, 6'd34, 6'd35, 6'd36, 6'd37, 6'd38, 6'd39,
        6'd40, 6'd41, 6'd42, 6'd43, 6'd44, 6'd45
    };

    result_t expected_sprites [$];

    function automatic sym_t shape_symbol(input logic [7:0] ch);
        case (ch)
            ".":     return S_PTH;
            "O":     return S_OUT;
            "W":     return S_WAL;
            "G":     return S_GHW;
            "A":     return S_AWL;
            "X":     return S_WOO;
            "-":     return S_DOR;
            default: return S_ANY;
        endcase
    endfunction

    function automatic logic cell_fits(input sym_t s, input logic [CELL_W-1:0] code,
                                       input logic off);
        logic is_wall;
        is_wall = (code == CT_WALL) || (code == CT_GHOST_WALL);
        case (s)
            S_ANY:   return 1'b1;
            S_PTH:   return !off && (code <= CT_LAST_PATH);
            S_OUT:   return off;
            S_WAL:   return code == CT_WALL;
            S_GHW:   return code == CT_GHOST_WALL;
            S_AWL:   return is_wall;
            S_WOO:   return is_wall || off;
            S_DOR:   return code == CT_DOOR;
            default: return 1'b0;
        endcase
    endfunction

    function automatic result_t classify_tile(input item_t t);
        logic [CELL_W-1:0] tile [CELL_COUNT];
        result_t           r;
        logic              hit;
        logic              found;
        tile[0] = t.cell_nw;
        tile[1] = t.cell_n;
        tile[2] = t.cell_ne;
        tile[3] = t.cell_w;
        tile[4] = t.cell_c;
        tile[5] = t.cell_e;
        tile[6] = t.cell_sw;
        tile[7] = t.cell_s;
        tile[8] = t.cell_se;
        r = '0;
        found = 1'b0;
        if (tile[4] != CT_WALL && tile[4] != CT_GHOST_WALL && tile[4] != CT_DOOR)
            return r;
        for (int p = 0; p < PATTERN_COUNT; p++)
        begin
            hit = 1'b1;
            for (int k = 0; k < CELL_COUNT; k++)
                hit = hit && cell_fits(shape_symbol(TILE_SHAPES[p][8*(CELL_COUNT-1-k) +: 8]),
                                       tile[k], t.outside_mask[k]);
            if (hit && !found)
            begin
                found = 1'b1;
                r.has_sprite = 1'b1;
                r.sprite_index = TILE_SPRITES[p];
            end
        end
        r.pattern_miss = !found;
        return r;
    endfunction

    initial
    begin
        mismatch_count = 0;
        sprites_owed = 0;
    end

    always @(posedge clk)
    begin : watch
        result_t want;
        if (rst_n && start && !busy)
            expected_sprites.push_back(classify_tile(item));
        if (rst_n && done)
        begin
            if (expected_sprites.size() == 0)
            begin
                if (mismatch_count < 10)
                    $display("unexpected result beat: has_sprite=%0d sprite=%0d miss=%0d",
                             result.has_sprite, result.sprite_index, result.pattern_miss);
                mismatch_count = mismatch_count + 1;
            end
            else
            begin
                want = expected_sprites.pop_front();
                if (result.has_sprite !== want.has_sprite
                    || result.sprite_index !== want.sprite_index
                    || result.pattern_miss !== want.pattern_miss)
                begin
                    if (mismatch_count < 10)
                        $display(
                            "result beat wrong: expected %0d/%0d/%0d, got %0d/%0d/%0d",
                            want.has_sprite, want.sprite_index, want.pattern_miss,
                            result.has_sprite, result.sprite_index,
                            result.pattern_miss);
                    mismatch_count = mismatch_count + 1;
                end
            end
        end
        sprites_owed <= expected_sprites.size();
    end

endmodule

>>> sim/tb.sv
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import wtpc_pkg::*;

    localparam logic [CELL_W-1:0] CT_OTHER = 4'd8;
    localparam int RANDOM_TILES = 2000;
    localparam int CALM_TAIL    = 300;
    localparam int CYCLE_LIMIT  = 200000;

    logic    clk = 1'b0;
    logic    rst_n = 1'b0;
    logic    start = 1'b0;
    item_t   item = '0;
    logic    busy;
    logic    done;
    result_t result;
    int      fails;
    int      owed;
    int      cycles = 0;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    wall_tile_pattern_classifier dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .busy   (busy),
        .item   (item),
        .done   (done),
        .result (result)
    );

    tile_sprite_checker checker_i (
        .clk            (clk),
        .rst_n          (rst_n),
        .start          (start),
        .busy           (busy),
        .item           (item),
        .done           (done),
        .result         (result),
        .mismatch_count (fails),
        .sprites_owed   (owed)
    );

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("wall_tile_pattern_classifier: mismatch");
            $finish;
        end
    end

    function automatic item_t set_cell(input item_t t, input int k,
                                       input logic [CELL_W-1:0] code, input logic off);
        item_t r;
        r = t;
        r[CELL_COUNT + CELL_W*(CELL_COUNT-1-k) +: CELL_W] = code;
        r.outside_mask[k] = off;
        return r;
    endfunction

    function automatic void fill_cell(input sym_t s, output logic [CELL_W-1:0] code,
                                      output logic off);
        code = CELL_W'($urandom_range(15));
        off = 1'($urandom_range(1));
        case (s)
            S_PTH:
            begin
                code = CELL_W'($urandom_range(CT_LAST_PATH));
                off = 1'b0;
            end
            S_OUT:   off = 1'b1;
            S_WAL:   code = CT_WALL;
            S_GHW:   code = CT_GHOST_WALL;
            S_AWL:   code = $urandom_range(1) ? CT_WALL : CT_GHOST_WALL;
            S_WOO:
            begin
                if ($urandom_range(1))
                    off = 1'b1;
                else
                    code = $urandom_range(1) ? CT_WALL : CT_GHOST_WALL;
            end
            S_DOR:   code = CT_DOOR;
            default: ;
        endcase
    endfunction

    function automatic item_t shaped_tile(input int p);
        item_t             t;
        logic [CELL_W-1:0] code;
        logic              off;
        t = '0;
        for (int k = 0; k < CELL_COUNT; k++)
        begin
            fill_cell(PATTERNS[p].cells[k], code, off);
            t = set_cell(t, k, code, off);
        end
        return t;
    endfunction

    function automatic item_t filled_tile(input logic [CELL_W-1:0] code,
                                          input logic [CELL_COUNT-1:0] mask);
        item_t t;
        t = '0;
        for (int k = 0; k < CELL_COUNT; k++)
            t = set_cell(t, k, code, mask[k]);
        return t;
    endfunction

    function automatic item_t random_tile();
        item_t t;
        int    pick;
        pick = $urandom_range(99);
        if (pick < 70)
        begin
            t = shaped_tile($urandom_range(PATTERN_COUNT - 1));
            if ($urandom_range(3) == 0)
                t = set_cell(t, $urandom_range(CELL_COUNT - 1),
                             CELL_W'($urandom_range(15)), 1'($urandom_range(1)));
        end
        else
        begin
            for (int k = 0; k < CELL_COUNT; k++)
                t = set_cell(t, k, CELL_W'($urandom_range(15)), 1'($urandom_range(1)));
            if (pick < 85)
                t.cell_c = CT_WALL + CELL_W'($urandom_range(2));
        end
        return t;
    endfunction

    task automatic send_tile(input item_t t);
        start <= 1'b1;
        item <= t;
        do
            @(posedge clk);
        while (busy);
    endtask

    task automatic hold_off(input int n);
        start <= 1'b0;
        repeat (n) @(posedge clk);
    endtask

    initial
    begin : stimulus
        item_t t;
        int    shapes [12];
        shapes = '{0, 1, 13, 14, 15, 16, 17, 21, 22, 34, 36, 45};

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        send_tile('0);
        send_tile('1);
        t = '0;
        t.cell_c = CT_OTHER;
        send_tile(t);
        send_tile(filled_tile(CT_WALL, '0));
        send_tile(filled_tile(CT_WALL, '1));
        send_tile(filled_tile(CT_GHOST_WALL, '0));
        t = '1;
        t.cell_c = CT_DOOR;
        send_tile(t);
        for (int k = 0; k < CELL_COUNT; k++)
            t = set_cell(t, k, CELL_W'(9 + k % 7), 1'b0);
        t.cell_c = CT_WALL;
        send_tile(t);
        t = filled_tile(CT_OTHER, '0);
        t.cell_c = CT_WALL;
        send_tile(t);
        t.cell_w = CT_LAST_PATH;
        t.outside_mask[5] = 1'b1;
        send_tile(t);
        t.outside_mask[3] = 1'b1;
        send_tile(t);
        foreach (shapes[i])
            send_tile(shaped_tile(shapes[i]));

        for (int i = 0; i < RANDOM_TILES; i++)
        begin
            if (i < RANDOM_TILES - CALM_TAIL && $urandom_range(5) == 0)
                hold_off($urandom_range(1, 18));
            send_tile(random_tile());
        end

        start <= 1'b0;
        @(posedge clk);
        while (owed != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);

        if (fails == 0)
            $display("wall_tile_pattern_classifier: match");
        else
            $display("wall_tile_pattern_classifier: mismatch");
        $finish;
    end

endmodule
